@@ hw/rtl/ptd_pkg.sv @@
// shared types and constants for the homogeneous point transform
package ptd_pkg;

    localparam int PT_W      = 32;
    localparam int PAIR_W    = 64;
    localparam int NUM_PAIRS = 8;
    localparam int CFG_IDX_W = 4;
    localparam int NUM_AXES  = 3;
    localparam int SUM_W     = 66;
    localparam int QUO_W     = 32;

    typedef logic [NUM_PAIRS-1:0][PAIR_W-1:0] mat_t;

    // identity matrix in Q16.16, column-major pairs
    localparam mat_t MAT_RESET = {
        64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
        64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000
    };

    typedef struct packed {
        logic signed [PT_W-1:0] point_x;
        logic signed [PT_W-1:0] point_y;
        logic signed [PT_W-1:0] point_z;
    } point_in_t;

    typedef struct packed {
        logic signed [PT_W-1:0] result_x;
        logic signed [PT_W-1:0] result_y;
        logic signed [PT_W-1:0] result_z;
        logic                   w_was_zero;
        logic                   saturated;
    } point_out_t;

    // classified item handed from front to back
    typedef struct packed {
        logic [NUM_AXES-1:0][SUM_W-1:0] mag;
        logic [NUM_AXES-1:0]            neg;
        logic [SUM_W-1:0]               den;
        logic                           w_was_zero;
    } ptd_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic signed [PT_W-1:0] mat_entry(input mat_t m, input int unsigned k);
        logic [PAIR_W-1:0] p;
        p = m[k[3:1]];
        return $signed(k[0] ? p[PAIR_W-1:PT_W] : p[PT_W-1:0]);
    endfunction

endpackage

@@ hw/rtl/ptd_front.sv @@
// front end: matrix products, row sums and classification of w
module ptd_front import ptd_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  mat_t      matrix,
    input  logic      s_valid,
    output logic      s_ready,
    input  point_in_t s_data,
    output logic      q_valid,
    input  logic      q_ready,
    output ptd_item_t q_data
);

    logic signed [2*PT_W-1:0] prod_reg [4][3];
    logic signed [PT_W-1:0]   cterm_reg [4];
    logic signed [SUM_W-1:0]  sum_reg [4];
    ptd_item_t                item_reg;
    logic                     v1_reg, v2_reg, v3_reg;
    logic                     en;

    assign en      = !v3_reg || q_ready;
    assign s_ready = en;
    assign q_valid = v3_reg;
    assign q_data  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 4; r++) begin
                prod_reg[r][0] <= mat_entry(matrix, r)     * s_data.point_x;
                prod_reg[r][1] <= mat_entry(matrix, r + 4) * s_data.point_y;
                prod_reg[r][2] <= mat_entry(matrix, r + 8) * s_data.point_z;
                cterm_reg[r]   <= mat_entry(matrix, r + 12);
                sum_reg[r] <= SUM_W'(prod_reg[r][0]) + SUM_W'(prod_reg[r][1])
                            + SUM_W'(prod_reg[r][2]) + (SUM_W'(cterm_reg[r]) <<< FRAC_BITS);
            end
            item_reg.w_was_zero <= (sum_reg[3] == '0);
            item_reg.den <= (sum_reg[3] == '0) ? (SUM_W'(1) << (2 * FRAC_BITS))
                          : (sum_reg[3][SUM_W-1] ? SUM_W'(-sum_reg[3]) : SUM_W'(sum_reg[3]));
            for (int a = 0; a < NUM_AXES; a++) begin
                item_reg.mag[a] <= sum_reg[a][SUM_W-1] ? SUM_W'(-sum_reg[a])
                                                       : SUM_W'(sum_reg[a]);
                item_reg.neg[a] <= sum_reg[a][SUM_W-1] ^ sum_reg[3][SUM_W-1];
            end
        end
    end

endmodule

@@ hw/rtl/ptd_queue.sv @@
// two-entry queue between front and back
module ptd_queue import ptd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  ptd_item_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output ptd_item_t out_data,
    output q_stat_t   stat
);

    ptd_item_t  mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready   = (count_reg != 2'd2);
    assign out_valid  = (count_reg != 2'd0);
    assign out_data   = mem_reg[rd_ptr_reg];
    assign push       = in_valid && in_ready;
    assign pop        = out_valid && out_ready;
    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 2'd1;
        else if (pop && !push) count_next = count_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= in_data;
    end

endmodule

@@ hw/rtl/ptd_back.sv @@
// back end: pipelined restoring division with sign and saturation
module ptd_back import ptd_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  ptd_item_t  in_data,
    output logic       m_valid,
    input  logic       m_ready,
    output point_out_t m_data
);

    localparam int NW = SUM_W + FRAC_BITS;
    localparam int CW = (NW > SUM_W + QUO_W) ? NW : SUM_W + QUO_W;

    logic [NW-1:0]       rem_reg [QUO_W+1][NUM_AXES];
    logic [QUO_W-1:0]    q_reg   [QUO_W+1][NUM_AXES];
    logic [NUM_AXES-1:0] ovf_reg [QUO_W+1];
    logic [NUM_AXES-1:0] neg_reg [QUO_W+1];
    logic [SUM_W-1:0]    den_reg [QUO_W+1];
    logic                wz_reg  [QUO_W+1];
    logic                v_reg   [QUO_W+1];
    logic                out_v_reg;
    point_out_t          out_reg;
    logic                en;

    assign en       = !out_v_reg || m_ready;
    assign in_ready = en;
    assign m_valid  = out_v_reg;
    assign m_data   = out_reg;

    // numerator scaling and the quotient overflow test
    always_ff @(posedge aclk) begin
        if (!aresetn) v_reg[0] <= 1'b0;
        else if (en)  v_reg[0] <= in_valid;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                rem_reg[0][a] <= NW'(in_data.mag[a]) << FRAC_BITS;
                q_reg[0][a]   <= '0;
                ovf_reg[0][a] <= (CW'(NW'(in_data.mag[a]) << FRAC_BITS))
                               >= (CW'(in_data.den) << QUO_W);
            end
            neg_reg[0] <= in_data.neg;
            den_reg[0] <= in_data.den;
            wz_reg[0]  <= in_data.w_was_zero;
        end
    end

    for (genvar s = 0; s < QUO_W; s++) begin : g_step
        localparam int BIT = QUO_W - 1 - s;
        logic [NW-1:0]    rem_next [NUM_AXES];
        logic [QUO_W-1:0] q_next   [NUM_AXES];

        always_comb begin
            logic [CW-1:0] dsh;
            logic [CW-1:0] rx;
            dsh = CW'(den_reg[s]) << BIT;
            for (int a = 0; a < NUM_AXES; a++) begin
                rx = CW'(rem_reg[s][a]);
                rem_next[a] = rem_reg[s][a];
                q_next[a]   = q_reg[s][a];
                if (rx >= dsh) begin
                    rem_next[a]   = NW'(rx - dsh);
                    q_next[a][BIT] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) v_reg[s+1] <= 1'b0;
            else if (en)  v_reg[s+1] <= v_reg[s];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    rem_reg[s+1][a] <= rem_next[a];
                    q_reg[s+1][a]   <= q_next[a];
                end
                ovf_reg[s+1] <= ovf_reg[s];
                neg_reg[s+1] <= neg_reg[s];
                den_reg[s+1] <= den_reg[s];
                wz_reg[s+1]  <= wz_reg[s];
            end
        end
    end

    // sign, clamp and output register
    logic [PT_W-1:0]     res [NUM_AXES];
    logic [NUM_AXES-1:0] sat;

    always_comb begin
        logic [QUO_W-1:0] q;
        for (int a = 0; a < NUM_AXES; a++) begin
            q = q_reg[QUO_W][a];
            if (neg_reg[QUO_W][a]) begin
                sat[a] = ovf_reg[QUO_W][a] || (q[QUO_W-1] && (q[QUO_W-2:0] != '0));
                res[a] = sat[a] ? {1'b1, {(PT_W-1){1'b0}}} : PT_W'(-q);
            end else begin
                sat[a] = ovf_reg[QUO_W][a] || q[QUO_W-1];
                res[a] = sat[a] ? {1'b0, {(PT_W-1){1'b1}}} : PT_W'(q);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) out_v_reg <= 1'b0;
        else if (en)  out_v_reg <= v_reg[QUO_W];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg.result_x   <= $signed(res[0]);
            out_reg.result_y   <= $signed(res[1]);
            out_reg.result_z   <= $signed(res[2]);
            out_reg.w_was_zero <= wz_reg[QUO_W];
            out_reg.saturated  <= |sat;
        end
    end

endmodule

@@ hw/rtl/point_transform_4x4_divide.sv @@
// top level: 4x4 homogeneous point transform with divide by w
// pipeline: 3 front stages, the queue register, 34 divider and output stages
// throughput: one transaction per cycle while m_ready does not stall the output,
//   set by the one-bit-per-stage divider pipeline
// reset: synchronous active-low aresetn clears all valid flags and the queue,
//   and loads the identity matrix
module point_transform_4x4_divide import ptd_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PAIR_W-1:0]    cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  point_in_t            s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output point_out_t           m_data
);

    // matrix pairs; the user must write them only while the block is idle (not enforced here)
    mat_t      matrix_reg;
    // front to queue
    logic      fq_valid, fq_ready;
    ptd_item_t fq_data;
    // queue to back
    logic      qb_valid, qb_ready;
    ptd_item_t qb_data;
    q_stat_t   q_stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            matrix_reg <= MAT_RESET;
        end else if (cfg_wr_en && (cfg_index < CFG_IDX_W'(NUM_PAIRS))) begin
            // writes past the last pair are dropped
            matrix_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    // products, sums and classification of w
    ptd_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .matrix  (matrix_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_data  (fq_data)
    );

    // decouples the front from back-pressure on the result side
    ptd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data),
        .stat      (q_stat)
    );

    // division, sign and saturation
    ptd_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (qb_valid),
        .in_ready (qb_ready),
        .in_data  (qb_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // queue cannot be both full and empty
    a_queue_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty");

    // a full queue with a finished front item must stall the input
    a_front_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_stat.full && fq_valid) |-> !s_ready)
        else $error("input accepted while front is blocked");

    // a saturated result carries at least one clamped coordinate
    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.saturated) |->
            (m_data.result_x == 32'sh7fffffff || m_data.result_x == 32'sh80000000 ||
             m_data.result_y == 32'sh7fffffff || m_data.result_y == 32'sh80000000 ||
             m_data.result_z == 32'sh7fffffff || m_data.result_z == 32'sh80000000))
        else $error("saturated flag without clamped coordinate");

endmodule

@@ tb/point_transform_checker.sv @@
// checker: watches the config, input and result channels, predicts each transformed point and compares
`timescale 1ns / 1ps
module point_transform_checker import ptd_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PAIR_W-1:0]    cfg_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  point_in_t            s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  point_out_t           m_data,
    output int                   fail_count,
    output int                   pending_count,
    output int                   checked_count,
    output int                   sat_count,
    output int                   wzero_count
);

    mat_t       matrix_shadow;
    point_out_t expected_points[$];

    // one matrix entry, sign-extended to the working width
    function automatic logic signed [127:0] coeff(input mat_t m, input int k);
        logic [PAIR_W-1:0]      pair;
        logic signed [PT_W-1:0] half;
        pair = m[k / 2];
        half = (k % 2) ? pair[63:32] : pair[31:0];
        return half;
    endfunction

    function automatic logic [PT_W-1:0] divide_clamp(input logic signed [127:0] num,
                                                     input logic signed [127:0] den,
                                                     inout logic clamped);
        logic         neg;
        logic [127:0] num_mag, den_mag, quo;
        neg     = num[127] ^ den[127];
        num_mag = num[127] ? -num : num;
        den_mag = den[127] ? -den : den;
        quo     = (num_mag << FRAC_BITS) / den_mag;
        if (neg) begin
            if (quo > 128'h8000_0000) begin
                clamped = 1'b1;
                return 32'h8000_0000;
            end
            return -quo[31:0];
        end
        if (quo > 128'h7fff_ffff) begin
            clamped = 1'b1;
            return 32'h7fff_ffff;
        end
        return quo[31:0];
    endfunction

    function automatic point_out_t project_point(input mat_t m, input point_in_t p);
        logic signed [127:0] px, py, pz;
        logic signed [127:0] row_acc [4];
        logic                clamped;
        point_out_t          r;
        px = p.point_x;
        py = p.point_y;
        pz = p.point_z;
        for (int row = 0; row < 4; row++) begin
            row_acc[row] = coeff(m, row) * px + coeff(m, row + 4) * py
                         + coeff(m, row + 8) * pz + (coeff(m, row + 12) <<< FRAC_BITS);
        end
        r.w_was_zero = (row_acc[3] == 0);
        if (r.w_was_zero) row_acc[3] = 128'sd1 <<< (2 * FRAC_BITS);
        clamped = 1'b0;
        r.result_x = divide_clamp(row_acc[0], row_acc[3], clamped);
        r.result_y = divide_clamp(row_acc[1], row_acc[3], clamped);
        r.result_z = divide_clamp(row_acc[2], row_acc[3], clamped);
        r.saturated = clamped;
        return r;
    endfunction

    assign pending_count = expected_points.size();

    always @(posedge aclk) begin
        if (!aresetn) begin
            matrix_shadow <= MAT_RESET;
        end else begin
            if (cfg_wr_en && cfg_index < NUM_PAIRS) matrix_shadow[cfg_index] <= cfg_data;
            if (s_valid && s_ready) expected_points.push_back(project_point(matrix_shadow, s_data));
            if (m_valid && m_ready) begin
                if (expected_points.size() == 0) begin
                    $display("%0t: unexpected result transaction, actual %h", $time, m_data);
                    fail_count++;
                end else begin
                    point_out_t exp_pt;
                    exp_pt = expected_points.pop_front();
                    checked_count++;
                    if (exp_pt.saturated) sat_count++;
                    if (exp_pt.w_was_zero) wzero_count++;
                    if (m_data.result_x !== exp_pt.result_x)
                        $display("%0t: result_x expected %h actual %h", $time,
                                 exp_pt.result_x, m_data.result_x);
                    if (m_data.result_y !== exp_pt.result_y)
                        $display("%0t: result_y expected %h actual %h", $time,
                                 exp_pt.result_y, m_data.result_y);
                    if (m_data.result_z !== exp_pt.result_z)
                        $display("%0t: result_z expected %h actual %h", $time,
                                 exp_pt.result_z, m_data.result_z);
                    if (m_data.w_was_zero !== exp_pt.w_was_zero)
                        $display("%0t: w_was_zero expected %b actual %b", $time,
                                 exp_pt.w_was_zero, m_data.w_was_zero);
                    if (m_data.saturated !== exp_pt.saturated)
                        $display("%0t: saturated expected %b actual %b", $time,
                                 exp_pt.saturated, m_data.saturated);
                    if (m_data !== exp_pt) fail_count++;
                end
            end
        end
    end

    initial begin
        fail_count    = 0;
        checked_count = 0;
        sat_count     = 0;
        wzero_count   = 0;
    end

endmodule

@@ tb/testbench.sv @@
// testbench top: stimulus, receiver back-pressure, watchdog and verdict
`timescale 1ns / 1ps
module testbench import ptd_pkg::*;;

    localparam int FRAC_BITS     = 16;
    localparam int WATCHDOG_MAX  = 5000;
    localparam int DRAIN_CYCLES  = 60;    // more than the full pipeline latency
    localparam int LONG_HOLD     = 300;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 4'd11;
    localparam logic [31:0] Q_ONE     = 32'h0001_0000;
    localparam logic [31:0] Q_NEG_ONE = 32'hffff_0000;
    localparam logic [31:0] Q_MAX     = 32'h7fff_ffff;
    localparam logic [31:0] Q_MIN     = 32'h8000_0000;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PAIR_W-1:0]    cfg_data;
    logic                 s_valid, s_ready;
    point_in_t            s_data;
    logic                 m_valid, m_ready;
    point_out_t           m_data;

    int fail_count, pending_count, checked_count, sat_count, wzero_count;
    int idle_cycles;
    bit sender_no_idle, receiver_no_idle, long_hold_request;
    int phases_run;

    point_transform_4x4_divide #(.FRAC_BITS(FRAC_BITS)) u_dut (
        .aclk, .aresetn, .cfg_wr_en, .cfg_index, .cfg_data,
        .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data
    );

    point_transform_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
        .aclk, .aresetn, .cfg_wr_en, .cfg_index, .cfg_data,
        .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .fail_count, .pending_count, .checked_count, .sat_count, .wzero_count
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // receiver: random back-pressure, plus one long hold on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold_request) begin
                m_ready <= 1'b0;
                for (int n = 0; n < LONG_HOLD; n++) @(posedge aclk);
                long_hold_request = 1'b0;
            end else begin
                m_ready <= receiver_no_idle || ($urandom_range(99) >= 8);
            end
        end
    end

    // watchdog: cycles in which no transaction happened on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_MAX) begin
                $display("%0t: watchdog expired, %0d results outstanding", $time, pending_count);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // one coordinate or matrix entry: a mix of full range, modest values and landmarks
    function automatic logic [31:0] pick_q();
        case ($urandom_range(5))
            0, 1: return $urandom;
            2, 3: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
            4: return $urandom_range(1) ? Q_ONE : Q_NEG_ONE;
            default: begin
                case ($urandom_range(3))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return 32'h0;
                    default: return 32'h1;
                endcase
            end
        endcase
    endfunction

    function automatic point_in_t make_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        point_in_t p;
        p.point_x = x;
        p.point_y = y;
        p.point_z = z;
        return p;
    endfunction

    // writes every pair, plus one write to an index past the list that must be ignored
    task automatic load_matrix(input mat_t m);
        for (int i = 0; i < NUM_PAIRS; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= i[CFG_IDX_W-1:0];
            cfg_data  <= m[i];
            @(posedge aclk);
        end
        cfg_index <= CFG_IDX_UNUSED;
        cfg_data  <= {$urandom, $urandom};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // one input transaction; valid only drops when an idle gap is taken
    task automatic send_point(input point_in_t p);
        if (!sender_no_idle && $urandom_range(99) < 8) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= p;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic finish_burst();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic mat_t entries_to_pairs(input logic [31:0] e [16]);
        mat_t m;
        for (int i = 0; i < NUM_PAIRS; i++) m[i] = {e[2*i+1], e[2*i]};
        return m;
    endfunction

    initial begin
        logic [31:0] ent [16];
        point_in_t   corner [8];

        aresetn           = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        s_valid           = 1'b0;
        s_data            = '0;
        sender_no_idle    = 1'b0;
        receiver_no_idle  = 1'b0;
        long_hold_request = 1'b0;
        idle_cycles       = 0;
        phases_run        = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset matrix: field extremes pass straight through the identity
        corner[0] = make_point(Q_MAX, Q_MIN, 32'h0);
        corner[1] = make_point(Q_MIN, Q_MAX, 32'h1);
        corner[2] = make_point(Q_ONE, Q_NEG_ONE, Q_MAX);
        corner[3] = make_point(32'h0, 32'h0, 32'h0);
        corner[4] = make_point(32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa);
        corner[5] = make_point(Q_MIN, Q_MIN, Q_MIN);
        corner[6] = make_point(Q_MAX, Q_MAX, Q_MAX);
        corner[7] = make_point(32'h0000_8000, 32'hffff_8000, 32'h1234_5678);
        foreach (corner[i]) send_point(corner[i]);
        finish_burst();
        wait_drained();

        // zero w: the w row all zero, so the divisor falls back to 1.0
        foreach (ent[i]) ent[i] = (i % 5 == 0 && i != 15) ? Q_ONE : 32'h0;
        ent[12] = 32'h0003_0000;
        load_matrix(entries_to_pairs(ent));
        foreach (corner[i]) send_point(corner[i]);
        finish_burst();
        wait_drained();

        // negative and tiny w: perspective with sign flips and saturating quotients
        foreach (ent[i]) ent[i] = 32'h0;
        ent[0] = Q_MAX;  ent[5] = Q_MIN; ent[10] = Q_ONE;
        ent[3] = 32'h0;  ent[7] = 32'h0; ent[11] = Q_NEG_ONE; ent[15] = 32'h1;
        load_matrix(entries_to_pairs(ent));
        foreach (corner[i]) send_point(corner[i]);
        send_point(make_point(Q_ONE, Q_ONE, 32'h0));
        finish_burst();
        wait_drained();

        // random phases with a fresh matrix each time
        for (int ph = 0; ph < 12; ph++) begin
            foreach (ent[i]) ent[i] = pick_q();
            if (ph % 4 == 1) begin
                // w row all zero throughout this phase
                ent[3] = 32'h0; ent[7] = 32'h0; ent[11] = 32'h0; ent[15] = 32'h0;
            end else if (ph % 4 == 2) begin
                // gentle projective w keeps most quotients in range
                ent[3] = 32'h0; ent[7] = 32'h0;
                ent[11] = $urandom_range(32'h0000_4000);
                ent[15] = $urandom_range(1) ? Q_ONE : Q_NEG_ONE;
            end
            if (ph == 0) ent = '{default: 32'h0};
            load_matrix(entries_to_pairs(ent));
            sender_no_idle   = (ph == 5);
            receiver_no_idle = (ph == 5) || (ph == 8);
            phases_run++;
            for (int n = 0; n < 100; n++) begin
                if (ph == 3 && n == 10) long_hold_request = 1'b1;
                if (ph == 7 && n == 50) begin
                    // sender pause until every result is back
                    finish_burst();
                    while (pending_count != 0) @(posedge aclk);
                end
                if (ph % 4 == 2 && $urandom_range(1))
                    send_point(make_point($urandom_range(32'h0010_0000) - 32'h0008_0000,
                                          $urandom_range(32'h0010_0000) - 32'h0008_0000,
                                          $urandom_range(32'h0010_0000) - 32'h0008_0000));
                else
                    send_point(make_point(pick_q(), pick_q(), pick_q()));
            end
            finish_burst();
            wait_drained();
        end

        // back to the identity to finish
        load_matrix(MAT_RESET);
        for (int n = 0; n < 20; n++) send_point(make_point($urandom, $urandom, $urandom));
        finish_burst();
        wait_drained();

        $display("run covered %0d results over %0d random matrices plus directed cases",
                 checked_count, phases_run);
        $display("of which %0d saturated and %0d had a zero w", sat_count, wzero_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
